// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define FCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define FCM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fcmac_pkg.sv =====
// types and constants of the fully connected layer engine
`default_nettype none

package fcmac_pkg;

	// load item as it arrives
	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         class_index;
		logic [7:0]         feature_index;
		logic signed [31:0] value;
		logic               row_end;
	} load_item_t;

	// score item as it leaves
	typedef struct packed {
		logic [3:0]         out_class;
		logic signed [31:0] score;
		logic               last;
	} score_item_t;

	// func codes of a load item
	localparam logic [1:0] FN_OFFSET  = 2'd0;
	localparam logic [1:0] FN_WEIGHT  = 2'd1;
	localparam logic [1:0] FN_FEATURE = 2'd2;

	typedef enum logic [1:0] {
		CMD_OFFSET  = 2'd0,
		CMD_WEIGHT  = 2'd1,
		CMD_FEATURE = 2'd2
	} cmd_kind_t;

	// classified command passed from front to back
	typedef struct packed {
		cmd_kind_t   kind;
		logic        wr_en;
		logic [3:0]  cls;
		logic [7:0]  feat;
		logic [31:0] data;
		logic        compute;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} fifo_status_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

endpackage

`default_nettype wire

// ===== design/fcmac_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module fcmac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/fcmac_front.sv =====
// front end: accepts load items, drops void ones, builds commands
`default_nettype none

module fcmac_front #(
	parameter int NUM_FEATURES = 256,
	parameter int NUM_CLASSES  = 10
) (
	input  wire logic                   load_valid,
	output logic                        load_ready,
	input  wire fcmac_pkg::load_item_t  load_item,
	input  wire fcmac_pkg::fifo_status_t q_status,
	output logic                        push,
	output fcmac_pkg::cmd_t             push_cmd
);

	logic cls_ok;
	logic feat_ok;
	logic keep;

	assign cls_ok  = int'(load_item.class_index) < NUM_CLASSES;
	assign feat_ok = int'(load_item.feature_index) < NUM_FEATURES;

	always_comb begin
		push_cmd         = '0;
		push_cmd.kind    = fcmac_pkg::CMD_OFFSET;
		push_cmd.cls     = load_item.class_index;
		push_cmd.feat    = load_item.feature_index;
		push_cmd.data    = load_item.value;
		keep             = 1'b0;
		case (load_item.func)
			fcmac_pkg::FN_OFFSET: begin
				push_cmd.kind  = fcmac_pkg::CMD_OFFSET;
				push_cmd.wr_en = cls_ok;
				keep           = cls_ok;
			end
			fcmac_pkg::FN_WEIGHT: begin
				push_cmd.kind  = fcmac_pkg::CMD_WEIGHT;
				push_cmd.wr_en = cls_ok && feat_ok;
				keep           = cls_ok && feat_ok;
			end
			fcmac_pkg::FN_FEATURE: begin
				push_cmd.kind    = fcmac_pkg::CMD_FEATURE;
				push_cmd.wr_en   = feat_ok;
				push_cmd.compute = load_item.row_end;
				keep             = feat_ok || load_item.row_end;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// void items are taken and dropped
	assign load_ready = !q_status.full;
	assign push       = load_valid && !q_status.full && keep;

endmodule

`default_nettype wire

// ===== design/fcmac_fifo.sv =====
// short command queue between front and back
`default_nettype none

module fcmac_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire fcmac_pkg::cmd_t        push_cmd,
	input  wire logic                   pop,
	output fcmac_pkg::fifo_status_t     status,
	output fcmac_pkg::cmd_t             head
);

	fcmac_pkg::cmd_t mem [fcmac_pkg::FIFO_DEPTH];

	logic [fcmac_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [fcmac_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [fcmac_pkg::FIFO_PTR_W:0]   count_q;

	assign status.full  = count_q == (fcmac_pkg::FIFO_PTR_W + 1)'(fcmac_pkg::FIFO_DEPTH);
	assign status.valid = count_q != '0;
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/fcmac_back.sv =====
// back end: store writes and the multiply accumulate sequencer
`default_nettype none

module fcmac_back #(
	parameter int NUM_FEATURES = 256,
	parameter int NUM_CLASSES  = 10,
	parameter int ACC_BITS     = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fcmac_pkg::fifo_status_t q_status,
	input  wire fcmac_pkg::cmd_t         head,
	output logic                         pop,
	output logic                         score_valid,
	input  wire logic                    score_ready,
	output fcmac_pkg::score_item_t       score_item
);

	localparam int FW  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int WD  = NUM_FEATURES * NUM_CLASSES;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_OFS   = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [CW-1:0]  cls_q;
	logic [FW-1:0]  k_q;
	logic [WAW-1:0] wadr_q;

	logic ofs_v_s1;
	logic rd_v_s1;
	logic prod_v_s2;

	logic signed [16:0]         prod_s2;
	logic signed [ACC_BITS-1:0] acc_q;

	logic        ofs_we, wgt_we, feat_we;
	logic [31:0] ofs_rdata;
	logic [7:0]  wgt_rdata;
	logic [7:0]  feat_rdata;
	logic [WAW-1:0] wgt_waddr;
	logic        emit;
	logic        last_cls;

	logic                    out_valid_q;
	fcmac_pkg::score_item_t  out_item_q;

	assign pop     = (state_q == ST_IDLE) && q_status.valid;
	assign ofs_we  = pop && head.wr_en && (head.kind == fcmac_pkg::CMD_OFFSET);
	assign wgt_we  = pop && head.wr_en && (head.kind == fcmac_pkg::CMD_WEIGHT);
	assign feat_we = pop && head.wr_en && (head.kind == fcmac_pkg::CMD_FEATURE);

	// weights stored class by class, so a row walks them in address order
	assign wgt_waddr = WAW'(head.cls) * WAW'(NUM_FEATURES) + WAW'(head.feat);

	fcmac_ram #(.WIDTH(32), .DEPTH(NUM_CLASSES)) u_ofs_ram (
		.clk   (clk),
		.we    (ofs_we),
		.waddr (CW'(head.cls)),
		.wdata (head.data),
		.raddr (cls_q),
		.rdata (ofs_rdata)
	);

	fcmac_ram #(.WIDTH(8), .DEPTH(WD)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (head.data[7:0]),
		.raddr (wadr_q),
		.rdata (wgt_rdata)
	);

	fcmac_ram #(.WIDTH(8), .DEPTH(NUM_FEATURES)) u_feat_ram (
		.clk   (clk),
		.we    (feat_we),
		.waddr (FW'(head.feat)),
		.wdata (head.data[7:0]),
		.raddr (k_q),
		.rdata (feat_rdata)
	);

	assign last_cls = cls_q == CW'(NUM_CLASSES - 1);
	assign emit     = (state_q == ST_EMIT) && (!out_valid_q || score_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cls_q       <= '0;
			k_q         <= '0;
			wadr_q      <= '0;
			ofs_v_s1    <= 1'b0;
			rd_v_s1     <= 1'b0;
			prod_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ofs_v_s1  <= state_q == ST_OFS;
			rd_v_s1   <= state_q == ST_MAC;
			prod_v_s2 <= rd_v_s1;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (score_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head.compute) begin
						cls_q   <= '0;
						wadr_q  <= '0;
						state_q <= ST_OFS;
					end
				end
				ST_OFS: begin
					k_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					k_q    <= k_q + 1'b1;
					wadr_q <= wadr_q + 1'b1;
					if (k_q == FW'(NUM_FEATURES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !prod_v_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						if (last_cls) begin
							state_q <= ST_IDLE;
						end else begin
							cls_q   <= cls_q + 1'b1;
							state_q <= ST_OFS;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: product register then wrapping accumulator
	always_ff @(posedge clk) begin
		prod_s2 <= $signed({1'b0, feat_rdata}) * $signed(wgt_rdata);
		if (ofs_v_s1) begin
			acc_q <= ACC_BITS'($signed(ofs_rdata));
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_BITS'(prod_s2);
		end
		if (emit) begin
			out_item_q.out_class <= 4'(cls_q);
			out_item_q.score     <= 32'(acc_q);
			out_item_q.last      <= last_cls;
		end
	end

	assign score_valid = out_valid_q;
	assign score_item  = out_item_q;

endmodule

`default_nettype wire

// ===== design/fixed_point_matrix_vector_mac_unit.sv =====
// top level of the fully connected layer engine
// stores: an accepted load item is written when the idle back pops it from the queue head
// throughput: one load item per cycle until the queue fills; a row end item then holds the back
//   until every class is scored, one product per cycle, and score stalls hold it longer
// reset: arst_n clears queue, sequencer and output valid; stores stay undefined until written
`default_nettype none

module fixed_point_matrix_vector_mac_unit #(
	parameter int NUM_FEATURES = 256,
	parameter int NUM_CLASSES  = 10,
	parameter int ACC_BITS     = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// load items: offsets, weights, features
	input  wire logic                   load_valid,
	output logic                        load_ready,
	input  wire fcmac_pkg::load_item_t  load_item,
	// score items, one per class after a row end
	output logic                        score_valid,
	input  wire logic                   score_ready,
	output fcmac_pkg::score_item_t      score_item
);

	// front to queue
	logic                    push;
	fcmac_pkg::cmd_t         push_cmd;
	// queue to back
	fcmac_pkg::fifo_status_t q_status;
	fcmac_pkg::cmd_t         head;
	logic                    pop;

	// the front decodes func and range checks the indices; items that would
	// do nothing are accepted and dropped here so they never reach the back
	fcmac_front #(
		.NUM_FEATURES (NUM_FEATURES),
		.NUM_CLASSES  (NUM_CLASSES)
	) u_front (
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load_item  (load_item),
		.q_status   (q_status),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// the queue lets loads keep arriving while a row is being scored, until it is full
	fcmac_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.status   (q_status),
		.head     (head)
	);

	// the back owns all three stores, so writes and reads keep item order;
	// a row is scored class by class, one product per cycle, and each score
	// goes out through a register that holds it until taken
	fcmac_back #(
		.NUM_FEATURES (NUM_FEATURES),
		.NUM_CLASSES  (NUM_CLASSES),
		.ACC_BITS     (ACC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head        (head),
		.pop         (pop),
		.score_valid (score_valid),
		.score_ready (score_ready),
		.score_item  (score_item)
	);

endmodule

`default_nettype wire

// ===== design/fcmac_checker.sv =====
// port level checks of the engine and their binding to the top level
`default_nettype none
`include "assert_macros.svh"

module fcmac_checker #(
	parameter int NUM_CLASSES = 10
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   score_valid,
	input wire logic                   score_ready,
	input wire fcmac_pkg::score_item_t score_item
);

	logic stall;
	logic last_ok;
	logic class_ok;

	assign stall    = score_valid && !score_ready;
	assign last_ok  = score_item.out_class == 4'(NUM_CLASSES - 1);
	assign class_ok = (NUM_CLASSES > 16) || (score_item.out_class <= 4'(NUM_CLASSES - 1));

	// a waiting score holds still
	`FCM_ASSERT(a_score_hold, stall |=> score_valid && $stable(score_item), "stalled score changed")

	// only the final class carries last
	`FCM_ASSERT(a_last_class, score_valid && score_item.last |-> last_ok, "last on a non-final class")

	// class index stays within the configured classes
	`FCM_ASSERT(a_class_range, score_valid |-> class_ok, "score class out of range")

	// score valid is cleared by reset, and this is checked even while reset is held
	`FCM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !score_valid, "score valid after reset")

endmodule

bind fixed_point_matrix_vector_mac_unit fcmac_checker #(
	.NUM_CLASSES (NUM_CLASSES)
) u_fcmac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.score_valid (score_valid),
	.score_ready (score_ready),
	.score_item  (score_item)
);

`default_nettype wire

// ===== sim/tb_fixed_point_matrix_vector_mac_unit.sv =====
// self-checking testbench of the fully connected layer engine, with score predictor
`timescale 1ns / 100ps

module tb_fixed_point_matrix_vector_mac_unit;

	// block sizes, kept at their defaults
	localparam int NUM_FEAT = 256;
	localparam int NUM_CLS  = 10;
	localparam int ACC_W    = 32;

	// func codes of the package under short names
	localparam logic [1:0] FN_OFFSET  = fcmac_pkg::FN_OFFSET;
	localparam logic [1:0] FN_WEIGHT  = fcmac_pkg::FN_WEIGHT;
	localparam logic [1:0] FN_FEATURE = fcmac_pkg::FN_FEATURE;
	// the one func code that the package leaves without a name
	localparam logic [1:0] FN_UNUSED = 2'd3;

	// accumulator wraps at ACC_W bits; the mask holds ones in the low ACC_W bits
	localparam logic [63:0] ACC_MASK = (64'd1 << ACC_W) - 64'd1;

	localparam int RANDOM_ITEMS   = 310;
	localparam int MAX_REPORTED   = 10;
	localparam int DRAIN_CYCLES   = 64;

	// one row of the directed table; typed rows carry hand-worked scores for the
	// first and the last class, every other score comes from the predictor
	typedef struct {
		fcmac_pkg::load_item_t item;
		bit                    typed;
		logic [31:0]           first_score;
		logic [31:0]           last_score;
	} directed_row_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   load_valid  = 1'b0;
	logic                   load_ready;
	fcmac_pkg::load_item_t  load_item   = '0;
	logic                   score_valid;
	logic                   score_ready = 1'b0;
	fcmac_pkg::score_item_t score_item;

	// predictor state: a shadow of the three stores
	logic [31:0]        class_offset_mem [NUM_CLS];
	logic signed [7:0]  weight_mem       [NUM_CLS][NUM_FEAT];
	logic [7:0]         feature_mem      [NUM_FEAT];

	fcmac_pkg::score_item_t pending_scores [$];
	directed_row_t          directed_rows  [$];
	fcmac_pkg::score_item_t want_score;
	int                     mismatches = 0;
	// remaining items of a no-idle stretch, load side then score side
	int                     burst_left [2] = '{0, 0};

	fixed_point_matrix_vector_mac_unit #(
		.NUM_FEATURES(NUM_FEAT),
		.NUM_CLASSES (NUM_CLS),
		.ACC_BITS    (ACC_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load_item  (load_item),
		.score_valid(score_valid),
		.score_ready(score_ready),
		.score_item (score_item)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle cycles before the next item: mostly random, now and then a stretch of none
	function automatic int draw_gap(int side);
		if (burst_left[side] > 0) begin
			burst_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left[side] = $urandom_range(4, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// offset plus dot product of one class, wrapped at the accumulator width
	// and sign-extended back to the 32-bit score
	function automatic logic [31:0] class_score(int cls);
		logic [63:0] acc;
		longint      prod;
		acc = {{32{class_offset_mem[cls][31]}}, class_offset_mem[cls]};
		for (int k = 0; k < NUM_FEAT; k++) begin
			prod = longint'(feature_mem[k]) * longint'(weight_mem[cls][k]);
			acc  = (acc + prod) & ACC_MASK;
		end
		if (acc[ACC_W-1])
			acc |= ~ACC_MASK;
		return acc[31:0];
	endfunction

	// effect of one accepted item on the shadow stores
	function automatic void store_load(fcmac_pkg::load_item_t it);
		case (it.func)
			FN_OFFSET: begin
				if (it.class_index < NUM_CLS)
					class_offset_mem[it.class_index] = it.value;
			end
			FN_WEIGHT: begin
				if (it.class_index < NUM_CLS && it.feature_index < NUM_FEAT)
					weight_mem[it.class_index][it.feature_index] = it.value[7:0];
			end
			FN_FEATURE: begin
				if (it.feature_index < NUM_FEAT)
					feature_mem[it.feature_index] = it.value[7:0];
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] fn, logic [3:0] cls, logic [7:0] feat,
			logic [31:0] val, logic row_end, bit typed, logic [31:0] first_score,
			logic [31:0] last_score);
		directed_row_t row;
		row.item.func          = fn;
		row.item.class_index   = cls;
		row.item.feature_index = feat;
		row.item.value         = val;
		row.item.row_end       = row_end;
		row.typed              = typed;
		row.first_score        = first_score;
		row.last_score         = last_score;
		directed_rows.push_back(row);
	endfunction

	// drive one load item from a falling edge, wait for its handshake, then queue
	// the scores it causes; returns at a falling edge with valid still high
	task automatic send_load(fcmac_pkg::load_item_t it, bit typed, logic [31:0] first_score,
			logic [31:0] last_score);
		int                     gap;
		fcmac_pkg::score_item_t want;
		gap = draw_gap(0);
		if (gap > 0) begin
			load_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		load_item  <= it;
		load_valid <= 1'b1;
		@(posedge clk);
		while (!load_ready)
			@(posedge clk);
		store_load(it);
		// a row end on a feature item yields one score per class, in class order
		if (it.func == FN_FEATURE && it.row_end) begin
			for (int c = 0; c < NUM_CLS; c++) begin
				want.out_class = 4'(c);
				want.last      = (c == NUM_CLS - 1);
				if (typed && c == 0)
					want.score = first_score;
				else if (typed && c == NUM_CLS - 1)
					want.score = last_score;
				else
					want.score = class_score(c);
				pending_scores.push_back(want);
			end
		end
		@(negedge clk);
	endtask

	// score side: ready drops for a random number of cycles before each item
	initial begin
		int gap;
		@(negedge clk);
		forever begin
			gap = draw_gap(1);
			if (gap > 0) begin
				score_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			score_ready <= 1'b1;
			@(posedge clk);
			while (!score_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// compare every accepted score item with the oldest one still pending
	always @(posedge clk) begin
		if (arst_n && score_valid && score_ready) begin
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("unexpected score item: class %0d score %h last %b",
						score_item.out_class, score_item.score, score_item.last);
			end else begin
				want_score = pending_scores.pop_front();
				if (score_item.out_class !== want_score.out_class ||
						score_item.score !== want_score.score ||
						score_item.last !== want_score.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display({"score mismatch: expected class %0d score %h last %b,",
							" got class %0d score %h last %b"},
							want_score.out_class, want_score.score, want_score.last,
							score_item.out_class, score_item.score, score_item.last);
				end
			end
		end
	end

	// stimulus
	initial begin
		fcmac_pkg::load_item_t it;
		int                    live_items;
		bit                    live;
		int                    pick;

		// directed table; classes 0 and NUM_CLS-1 start with zero offset and
		// weights and all features start at zero, so their scores are known by hand
		// a row end straight after the preload: both edge classes score zero
		add_row(FN_FEATURE, 4'd0, 8'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 32'h0);
		// most positive and most negative offsets on the edge classes
		add_row(FN_OFFSET, 4'd0, 8'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0);
		add_row(FN_OFFSET, 4'(NUM_CLS - 1), 8'd0, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 32'h0);
		// offset loads to classes past the end are dropped
		add_row(FN_OFFSET, 4'(NUM_CLS), 8'd0, 32'h1234_5678, 1'b0, 1'b0, 32'h0, 32'h0);
		add_row(FN_OFFSET, 4'hF, 8'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0);
		// upper value bits of a feature are ignored; scores are the bare offsets
		add_row(FN_FEATURE, 4'd0, 8'hFF, 32'hFFFF_FF00, 1'b1, 1'b1,
			32'h7FFF_FFFF, 32'h8000_0000);
		// weight +1 and weight -128 on the top feature
		add_row(FN_WEIGHT, 4'd0, 8'hFF, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 32'h0);
		add_row(FN_WEIGHT, 4'(NUM_CLS - 1), 8'hFF, 32'hFFFF_FF80, 1'b0, 1'b0, 32'h0, 32'h0);
		// feature 255 at full scale: both edge scores wrap past the 32-bit limit
		add_row(FN_FEATURE, 4'd0, 8'hFF, 32'h0000_00FF, 1'b1, 1'b1,
			32'h8000_00FE, 32'h7FFF_8080);
		// unused func, even with a row end, does nothing
		add_row(FN_UNUSED, 4'd3, 8'd9, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0);
		add_row(FN_WEIGHT, 4'(NUM_CLS), 8'd0, 32'h0000_007F, 1'b0, 1'b0, 32'h0, 32'h0);
		// row end on weight and offset items: the load happens, no scores
		add_row(FN_WEIGHT, 4'd0, 8'd0, 32'h0000_007F, 1'b1, 1'b0, 32'h0, 32'h0);
		add_row(FN_OFFSET, 4'd0, 8'd0, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0);
		// a feature written twice keeps the later value
		add_row(FN_FEATURE, 4'd0, 8'd0, 32'hFFFF_FF01, 1'b0, 1'b0, 32'h0, 32'h0);
		add_row(FN_FEATURE, 4'd0, 8'd0, 32'h0000_0080, 1'b0, 1'b0, 32'h0, 32'h0);
		// 128 * 127 + 255 * 1 on class 0, offset minus 255 * 128 on the last class
		add_row(FN_FEATURE, 4'd0, 8'h80, 32'h5A5A_5A00, 1'b1, 1'b1,
			32'h0000_407F, 32'h7FFF_8080);
		add_row(FN_WEIGHT, 4'd5, 8'd7, 32'h0000_00A5, 1'b0, 1'b0, 32'h0, 32'h0);
		add_row(FN_WEIGHT, 4'hF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0);
		add_row(FN_FEATURE, 4'd0, 8'd7, 32'hFFFF_FFC3, 1'b1, 1'b0, 32'h0, 32'h0);
		add_row(FN_FEATURE, 4'hA, 8'hAA, 32'h8765_43FF, 1'b1, 1'b0, 32'h0, 32'h0);

		// hold reset, then release it on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// preload every store entry, so no score ever reads an unwritten one;
		// the edge classes get zero offsets and weights, the features all zero
		for (int c = 0; c < NUM_CLS; c++) begin
			it               = '0;
			it.func          = FN_OFFSET;
			it.class_index   = 4'(c);
			it.value         = (c == 0 || c == NUM_CLS - 1) ? 32'h0 : $urandom;
			it.row_end       = 1'($urandom_range(0, 1));
			send_load(it, 1'b0, 32'h0, 32'h0);
		end
		for (int c = 0; c < NUM_CLS; c++) begin
			for (int f = 0; f < NUM_FEAT; f++) begin
				it               = '0;
				it.func          = FN_WEIGHT;
				it.class_index   = 4'(c);
				it.feature_index = 8'(f);
				it.value         = $urandom;
				if (c == 0 || c == NUM_CLS - 1)
					it.value[7:0] = 8'h00;
				send_load(it, 1'b0, 32'h0, 32'h0);
			end
		end
		for (int f = 0; f < NUM_FEAT; f++) begin
			it               = '0;
			it.func          = FN_FEATURE;
			it.class_index   = 4'($urandom_range(0, 15));
			it.feature_index = 8'(f);
			it.value         = $urandom & 32'hFFFF_FF00;
			send_load(it, 1'b0, 32'h0, 32'h0);
		end

		foreach (directed_rows[i])
			send_load(directed_rows[i].item, directed_rows[i].typed,
				directed_rows[i].first_score, directed_rows[i].last_score);

		// random part: mostly weight and feature traffic with the odd row end,
		// a little noise of unused funcs and classes past the end
		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			pick             = $urandom_range(0, 99);
			it.value         = $urandom;
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: it.value[7:0] = 8'h80;
					1: it.value[7:0] = 8'h7F;
					2: it.value[7:0] = 8'h00;
					default: it.value[7:0] = 8'hFF;
				endcase
			end
			it.feature_index = 8'($urandom_range(0, 255));
			it.class_index   = ($urandom_range(0, 7) == 0) ?
				4'($urandom_range(NUM_CLS, 15)) : 4'($urandom_range(0, NUM_CLS - 1));
			it.row_end       = ($urandom_range(0, 9) == 0);
			if (pick < 5) begin
				it.func = FN_UNUSED;
				live    = 1'b0;
			end else if (pick < 15) begin
				it.func = FN_OFFSET;
				live    = (it.class_index < NUM_CLS);
			end else if (pick < 60) begin
				it.func = FN_WEIGHT;
				live    = (it.class_index < NUM_CLS);
			end else begin
				it.func = FN_FEATURE;
				live    = 1'b1;
			end
			send_load(it, 1'b0, 32'h0, 32'h0);
			if (live)
				live_items++;
		end
		load_valid <= 1'b0;

		// drain, then a short quiet spell to catch stray score items
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
